// File: rtl/core/lvp_pkg.sv
// Shared types and character constants for the label/value line parser.
// Used by lvp_line_fsm, lvp_accum and the top level; no dependencies.
package lvp_pkg;

    localparam logic [7:0] C_TAB   = 8'd9;
    localparam logic [7:0] C_LF    = 8'd10;
    localparam logic [7:0] C_CR    = 8'd13;
    localparam logic [7:0] C_SPACE = 8'd32;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_CHR_V = 8'h56;
    localparam logic [7:0] C_CHR_P = 8'h50;

    localparam int DEC_DIVISOR = 1000;

    localparam logic KIND_VOLTS = 1'b0;
    localparam logic KIND_WATTS = 1'b1;

    typedef struct packed {
        logic       clear;
        logic       take;
        logic [3:0] digit;
        logic       emit;
        logic       kind;
        logic       neg;
    } t_ctl;

endpackage

// File: rtl/core/label_tab_value_line_parser.sv
// Label/value line parser top level: input register, line control, accumulator, result register.
// Depends on lvp_pkg, lvp_line_fsm and lvp_accum.
//
// Usage:
//   Input channel i_rx_valid / o_rx_stall carries one received byte per request
//   (i_rx_byte). Lines read "label TAB value CR LF"; labels V and PPV are decoded.
//   Output channel o_reading_valid / i_reading_stall carries one reading per
//   matching LF: o_reading_kind (0 volts, 1 watts) and o_reading_value (signed).
//   Throughput: one byte per cycle while o_rx_stall is low; the per-byte work is one multiply-by-ten
//   accumulate between the input register and the result register.
//   A reading is loaded into the result register when its LF leaves the input register.
//   i_cfg_wr_en / i_cfg_wr_data write the enable bit (reset 1); when clear,
//   bytes are taken and dropped, and a partial line is kept.
//   Reset (i_rst_n low, synchronous) empties both registers and clears the line.
//   A stalled reading holds; the input register keeps accepting bytes that give
//   no reading, and o_rx_stall rises only when an LF meets a full, stalled output.
module label_tab_value_line_parser #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_reading_valid,
    input  logic        i_reading_stall,
    output logic        o_reading_kind,
    output logic [31:0] o_reading_value
);
    import lvp_pkg::*;

    logic        r_enable;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_value;

    t_ctl        ctl;
    logic [31:0] value;
    logic        out_free;
    logic        proc;
    logic        step;
    logic        in_acc;

    assign out_free   = !r_out_valid || !i_reading_stall;
    assign proc       = r_in_valid && (out_free || !(r_enable && ctl.emit));
    assign step       = proc && r_enable;
    assign o_rx_stall = r_in_valid && !proc;
    assign in_acc     = i_rx_valid && !o_rx_stall;

    lvp_line_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_ctl   (ctl)
    );

    lvp_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ctl   (ctl),
        .o_value (value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (step && ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_reading_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && ctl.emit) begin
            r_out_kind  <= ctl.kind;
            r_out_value <= value;
        end
    end

    assign o_reading_valid = r_out_valid;
    assign o_reading_kind  = r_out_kind;
    assign o_reading_value = r_out_value;

endmodule

// File: rtl/core/lvp_line_fsm.sv
// Line framing, label match, sign and held-byte control for the parser.
// Depends on lvp_pkg; drives the digit accumulator through a t_ctl struct.
module lvp_line_fsm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    output lvp_pkg::t_ctl o_ctl
);
    import lvp_pkg::*;

    typedef enum logic [1:0] {
        PH_LABEL,
        PH_LEAD,
        PH_DIGITS,
        PH_ENDED
    } t_phase;

    typedef enum logic [2:0] {
        LM_EMPTY,
        LM_V,
        LM_P,
        LM_PP,
        LM_PPV,
        LM_BAD
    } t_label;

    t_phase     r_phase, n_phase;
    t_label     r_label, n_label;
    logic       r_neg, n_neg;
    logic [7:0] r_held, n_held;
    logic       r_held_valid, n_held_valid;

    logic       held_digit;
    logic       held_space;
    logic       take;

    always_comb begin
        held_digit = (r_held >= C_ZERO) && (r_held <= C_NINE);
        held_space = (r_held == C_SPACE) || (r_held inside {[C_TAB:C_CR]});
        n_phase      = r_phase;
        n_label      = r_label;
        n_neg        = r_neg;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        take         = 1'b0;
        if (i_byte == C_LF) begin
            n_phase      = PH_LABEL;
            n_label      = LM_EMPTY;
            n_neg        = 1'b0;
            n_held       = '0;
            n_held_valid = 1'b0;
        end else if (r_phase == PH_LABEL) begin
            if (i_byte == C_TAB) begin
                n_phase = PH_LEAD;
            end else begin
                case (r_label)
                    LM_EMPTY: begin
                        n_label = (i_byte == C_CHR_V) ? LM_V :
                                  (i_byte == C_CHR_P) ? LM_P : LM_BAD;
                    end
                    LM_P:    n_label = (i_byte == C_CHR_P) ? LM_PP : LM_BAD;
                    LM_PP:   n_label = (i_byte == C_CHR_V) ? LM_PPV : LM_BAD;
                    default: n_label = LM_BAD;
                endcase
            end
        end else begin
            if (r_held_valid) begin
                case (r_phase)
                    PH_LEAD: begin
                        if (held_space) begin
                            n_phase = PH_LEAD;
                        end else if (r_held == C_PLUS) begin
                            n_phase = PH_DIGITS;
                        end else if (r_held == C_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_DIGITS;
                        end else if (held_digit) begin
                            take    = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_ENDED;
                        end
                    end
                    PH_DIGITS: begin
                        if (held_digit) begin
                            take = 1'b1;
                        end else begin
                            n_phase = PH_ENDED;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
            n_held       = i_byte;
            n_held_valid = 1'b1;
        end
    end

    always_comb begin
        o_ctl.clear = (i_byte == C_LF);
        o_ctl.take  = take;
        o_ctl.digit = 4'(r_held - C_ZERO);
        o_ctl.emit  = (i_byte == C_LF) && (r_phase != PH_LABEL) &&
                      ((r_label == LM_V) || (r_label == LM_PPV));
        o_ctl.kind  = (r_label == LM_PPV) ? KIND_WATTS : KIND_VOLTS;
        o_ctl.neg   = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LABEL;
            r_label      <= LM_EMPTY;
            r_neg        <= 1'b0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_label      <= n_label;
            r_neg        <= n_neg;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

// File: rtl/core/lvp_accum.sv
// Saturating decimal accumulator with a running quotient and remainder by 1000.
// Depends on lvp_pkg; steered by the t_ctl struct from lvp_line_fsm.
module lvp_accum #(
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  lvp_pkg::t_ctl i_ctl,
    output logic [31:0]   o_value
);
    import lvp_pkg::*;

    localparam int OW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam logic [VALUE_BITS-1:0] LIM   = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] DIV_K = VALUE_BITS'(DEC_DIVISOR);
    localparam logic [VALUE_BITS-1:0] LIM_Q_NEG = LIM / DIV_K;
    localparam logic [VALUE_BITS-1:0] LIM_Q_POS = (LIM - 1'b1) / DIV_K;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [9:0]            r_rem, n_rem;

    logic [VALUE_BITS+3:0] prod;
    logic [VALUE_BITS+3:0] quo_prod;
    logic [13:0]           rem_ext;
    logic [3:0]            qd;
    logic                  at_lim;
    logic [VALUE_BITS-1:0] mag_v;
    logic [VALUE_BITS-1:0] mag_w;
    logic [OW-1:0]         mag;
    logic [OW-1:0]         signed_val;

    always_comb begin
        prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
               (VALUE_BITS+4)'(i_ctl.digit);
        rem_ext = (14'(r_rem) << 3) + (14'(r_rem) << 1) + 14'(i_ctl.digit);
        qd = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem_ext >= 14'(k * DEC_DIVISOR)) begin
                qd = 4'(k);
            end
        end
        quo_prod = ({4'b0, r_quo} << 3) + ({4'b0, r_quo} << 1) +
                   (VALUE_BITS+4)'(qd);
        n_acc = r_acc;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_ctl.clear) begin
            n_acc = '0;
            n_quo = '0;
            n_rem = '0;
        end else if (i_ctl.take) begin
            if (prod > {4'b0, LIM}) begin
                n_acc = LIM;
            end else begin
                n_acc = prod[VALUE_BITS-1:0];
                n_quo = quo_prod[VALUE_BITS-1:0];
                n_rem = 10'(rem_ext - 14'(qd) * 14'(DEC_DIVISOR));
            end
        end
    end

    always_comb begin
        at_lim = (r_acc == LIM);
        if (at_lim) begin
            mag_v = i_ctl.neg ? LIM_Q_NEG : LIM_Q_POS;
        end else begin
            mag_v = r_quo;
        end
        mag_w      = (at_lim && !i_ctl.neg) ? (LIM - 1'b1) : r_acc;
        mag        = OW'((i_ctl.kind == KIND_WATTS) ? mag_w : mag_v);
        signed_val = i_ctl.neg ? (~mag + 1'b1) : mag;
        o_value    = signed_val[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_quo <= '0;
            r_rem <= '0;
        end else if (i_step) begin
            r_acc <= n_acc;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

endmodule

// File: rtl/core/lvp_port_check.sv
// Port-level checks for the label/value line parser, bound to its top level.
// Depends only on the top level's ports.
module lvp_port_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_stall,
    input logic        o_reading_valid,
    input logic        i_reading_stall,
    input logic        o_reading_kind,
    input logic [31:0] o_reading_value
);

    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_reading_valid)
        else $error("reading valid after reset");

    a_reset_in_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rx_stall)
        else $error("input stalled after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (o_reading_valid && i_reading_stall))
        else $error("input stalled without a blocked reading");

    a_hold_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_reading_valid && i_reading_stall) |=>
            (o_reading_valid && $stable(o_reading_value) && $stable(o_reading_kind)))
        else $error("stalled reading changed");

endmodule

bind label_tab_value_line_parser lvp_port_check u_port_check (.*);
